// File: hdl/weighted_zone_class_histogram_assert.svh
// Assertion macros used by the histogram RTL.
`ifndef WEIGHTED_ZONE_CLASS_HISTOGRAM_ASSERT_SVH
`define WEIGHTED_ZONE_CLASS_HISTOGRAM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WZCH_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WZCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/wzch_pkg.sv
`timescale 1ns / 1ps
package wzch_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_WR
  } wzch_state_t;

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  localparam logic [7:0] PROTECT_FULL = 8'd255;
  localparam logic [7:0] PROTECT_PART = 8'd1;

  localparam logic [1:0] CLASS_OTHER = 2'd0;
  localparam logic [1:0] CLASS_PART  = 2'd1;
  localparam logic [1:0] CLASS_FULL  = 2'd2;
  localparam logic [1:0] CLASS_NONE  = 2'd3;

  localparam int unsigned CLASSES = 3;

  localparam logic signed [7:0] SCALE = 8'sd100;

  localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

endpackage

// File: hdl/weighted_zone_class_histogram.sv
`timescale 1ns / 1ps
// Weighted zone/class histogram: keeps one saturating signed 64-bit sum per
// zone and protection class in a single synchronous RAM of REGIONS*3 words.
// After reset the block sweeps the RAM to zero, one word per cycle, with
// in_ready held low. Each transaction then passes through the acceptance
// cycle, which issues the RAM read and the area-rate multiply, then the
// scaling multiply, the saturating add and the write-back, at whose end the
// result is loaded into the output register. For the read-modify-write of the
// RAM, in_ready is high only in the idle state, so a new transaction is taken
// only once the previous one is through its write-back. A result waiting in
// the output register holds the block in the write-back stage, and in_ready
// stays low until that result has left. Accumulations to zones at or beyond
// REGIONS are flagged as dropped, and reads of a non-existent bin return zero.
`include "weighted_zone_class_histogram_assert.svh"
module weighted_zone_class_histogram
  import wzch_pkg::*;
#(
  parameter int REGIONS = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [15:0] in_zone_code,
  input  logic [7:0]         in_protect_code,
  input  logic [22:0]        in_cell_area,
  input  logic signed [17:0] in_fert_rate,
  input  logic [13:0]        in_read_zone,
  input  logic [1:0]         in_read_class,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic signed [63:0] out_bin_sum,
  output logic               out_bin_positive,
  output logic               out_dropped
);

  localparam int DEPTH = REGIONS * CLASSES;
  localparam int AW = $clog2(DEPTH);
  localparam logic [16:0] REGIONS_W = 17'(REGIONS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  wzch_state_t state_r, state_nxt;

  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r, out_kind_nxt;
  logic signed [63:0] out_sum_r, out_sum_nxt;
  logic          out_pos_r, out_pos_nxt;
  logic          out_drop_r, out_drop_nxt;

  logic          op_r;
  logic          drop_r;
  logic          do_write_r;
  logic          rd_ok_r;
  logic [AW-1:0] addr_r;
  logic signed [41:0] prod_r;
  logic signed [49:0] scaled_r;
  logic signed [63:0] sum_r, sum_nxt;

  logic          accept;
  logic [15:0]   zone_eff;
  logic [16:0]   zone_ext;
  logic [1:0]    acc_class;
  logic [17:0]   acc_idx;
  logic [17:0]   rd_idx;
  logic          acc_drop;
  logic          rd_ok;
  logic [AW-1:0] in_addr;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic [63:0]   ram_rdata;

  logic signed [63:0] addend;
  logic signed [63:0] raw_sum;
  logic               out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    zone_eff = in_zone_code[15] ? 16'd0 : in_zone_code;
    zone_ext = {1'b0, zone_eff};
    acc_drop = (zone_ext >= REGIONS_W);
    case (in_protect_code)
      PROTECT_FULL: acc_class = CLASS_FULL;
      PROTECT_PART: acc_class = CLASS_PART;
      default:      acc_class = CLASS_OTHER;
    endcase
    acc_idx = {zone_ext, 1'b0} + {1'b0, zone_ext} + {16'd0, acc_class};
    rd_ok   = ({3'd0, in_read_zone} < REGIONS_W) && (in_read_class != CLASS_NONE);
    rd_idx  = {3'd0, in_read_zone, 1'b0} + {4'd0, in_read_zone} + {16'd0, in_read_class};
    if (in_op == OP_ACC) begin
      in_addr = acc_drop ? '0 : acc_idx[AW-1:0];
    end else begin
      in_addr = rd_ok ? rd_idx[AW-1:0] : '0;
    end
  end

  always_comb begin
    addend  = {{14{scaled_r[49]}}, scaled_r};
    raw_sum = $signed(ram_rdata) + addend;
    if ((ram_rdata[63] == addend[63]) && (raw_sum[63] != ram_rdata[63])) begin
      sum_nxt = ram_rdata[63] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = raw_sum;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_sum_nxt   = out_sum_r;
    out_pos_nxt   = out_pos_r;
    out_drop_nxt  = out_drop_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = sum_r;
    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        if (out_free) begin
          ram_we        = do_write_r;
          out_valid_nxt = 1'b1;
          if (op_r == OP_ACC) begin
            out_kind_nxt = KIND_ACK;
            out_sum_nxt  = '0;
            out_pos_nxt  = 1'b0;
            out_drop_nxt = drop_r;
          end else begin
            out_kind_nxt = KIND_DATA;
            out_sum_nxt  = rd_ok_r ? $signed(ram_rdata) : '0;
            out_pos_nxt  = rd_ok_r && !ram_rdata[63] && (ram_rdata != '0);
            out_drop_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_sum_r  <= out_sum_nxt;
    out_pos_r  <= out_pos_nxt;
    out_drop_r <= out_drop_nxt;
    if (accept) begin
      op_r       <= in_op;
      drop_r     <= acc_drop;
      do_write_r <= (in_op == OP_ACC) && !acc_drop && (in_cell_area != '0);
      rd_ok_r    <= rd_ok;
      addr_r     <= in_addr;
      prod_r     <= 42'($signed({1'b0, in_cell_area})) * 42'(in_fert_rate);
    end
    if (state_r == ST_MUL) begin
      scaled_r <= 50'(prod_r) * 50'(SCALE);
    end
    if (state_r == ST_ADD) begin
      sum_r <= sum_nxt;
    end
  end

  wzch_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_bin_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (accept),
    .rd_addr(in_addr),
    .rd_data(ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_bin_sum      = out_sum_r;
  assign out_bin_positive = out_pos_r;
  assign out_dropped      = out_drop_r;

  `WZCH_ASSERT_SAME(a_write_window, clk, rst_n, ram_we,
    (state_r == ST_CLEAR) || (state_r == ST_WR), "RAM written outside clear or write-back")
  `WZCH_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept,
    (state_r == ST_MUL) && !in_ready, "accepted transaction did not enter the multiply stage")
  `WZCH_ASSERT_SAME(a_ack_zero, clk, rst_n, out_valid && (out_kind == KIND_ACK),
    (out_bin_sum == '0) && !out_bin_positive, "acknowledgement carries bin data")
  `WZCH_ASSERT_SAME(a_positive_sum, clk, rst_n, out_valid && out_bin_positive,
    (out_kind == KIND_DATA) && !out_bin_sum[63] && !out_dropped,
    "positive flag inconsistent with result")

endmodule

// File: hdl/wzch_ram.sv
`timescale 1ns / 1ps
module wzch_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
